### hdl/sf4_pkg.sv
package sf4_pkg;

    typedef struct packed {
        logic signed [31:0] lane_x;
        logic signed [31:0] lane_y;
        logic signed [31:0] lane_z;
        logic signed [31:0] lane_w;
        logic [7:0]         iteration;
        logic [47:0]        distance_factor;
    } sf4_point_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic [47:0]        out_factor;
    } sf4_result_t;

    // One coefficient pair written by the trig sequencer.
    typedef struct packed {
        logic               we;
        logic [2:0]         plane;
        logic signed [17:0] cos_val;
        logic signed [17:0] sin_val;
    } sf4_coef_wr_t;

    typedef enum logic [2:0] {
        REG_SCALE,
        REG_OFFSET,
        REG_OFF_WIN,
        REG_ROT_CTRL,
        REG_ANG_FIRST,
        REG_ANG_SECOND,
        REG_DE_GAIN,
        REG_DE_OFFSET
    } sf4_reg_t;

    localparam int NUM_PLANES = 6;
    localparam int TRIG_STEPS = 11;
    localparam int SIN_STEPS  = 5;

    // ceil(2^41 / k); the quotient floor(d * r / 2^41) is exact for any
    // 33-bit dividend d as long as k is below 256.
    function automatic logic [40:0] recip_k(input int unsigned k);
        return 41'(((64'd1 << 41) + 64'(k) - 64'd1) / 64'(k));
    endfunction

    // Horner divisors as reciprocals: five sine steps, then six cosine steps.
    localparam logic [40:0] RECIP_K [TRIG_STEPS] = '{
        recip_k(110), recip_k(72), recip_k(42), recip_k(20), recip_k(6),
        recip_k(132), recip_k(90), recip_k(56), recip_k(30), recip_k(12), recip_k(2)
    };

    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [17:0] COEF_ONE    = 18'sd65536;

    // Lane pair of each rotation plane: xy yz xz xw yw zw.
    localparam int PLANE_A [NUM_PLANES] = '{0, 1, 0, 0, 1, 2};
    localparam int PLANE_B [NUM_PLANES] = '{1, 2, 2, 3, 3, 3};

endpackage

### hdl/sierpinski_4d_fold_rotate_step.sv
// Channel   Payload        Valid          Stall          Direction
// point     sf4_point_t    point_valid    point_stall    into the block
// result    sf4_result_t   result_valid   result_stall   out of the block
// config    APB, 64 bits   psel/penable   pready (high)  register at 8*index
//
// A request enters in every cycle that point_stall is low and appears on the result port
// from the last of 17 pipeline registers; the rate is one per cycle while not stalled.
// A write to an angle register queues a run of the shared trig sequencer, and
// point_stall stays high until all queued runs end.
// Reset clears the valid bits and returns the registers and coefficients to defaults.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
module sierpinski_4d_fold_rotate_step (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 point_valid,
    output logic                 point_stall,
    input  sf4_pkg::sf4_point_t  point,
    output logic                 result_valid,
    input  logic                 result_stall,
    output sf4_pkg::sf4_result_t result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);
    import sf4_pkg::*;

    localparam int NUM_STAGES = 17;
    localparam int LAST = NUM_STAGES - 1;

    typedef struct packed {
        logic [3:0][31:0] v;
        logic [3:0][63:0] p;
        logic [7:0]       it;
        logic             rot;
        logic [47:0]      fac;
    } stage_t;

    logic [31:0]        scale_reg;
    logic [63:0]        offset_reg;
    logic [15:0]        off_win_reg;
    logic [16:0]        rot_ctrl_reg;
    logic [47:0]        ang_first_reg;
    logic [47:0]        ang_second_reg;
    logic [31:0]        gain_reg;
    logic [47:0]        de_off_reg;
    logic signed [17:0] cos_reg [NUM_PLANES];
    logic signed [17:0] sin_reg [NUM_PLANES];
    logic [1:0]         ang_pend_reg;
    logic [1:0]         ang_pend_next;

    stage_t                st_reg  [NUM_STAGES];
    stage_t                st_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [63:0]           ag_reg;
    logic [55:0]           fpp_reg [4];
    logic [80:0]           fa_reg;
    logic [80:0]           fb_reg;
    logic [112:0]          full_reg;

    sf4_reg_t     cfg_idx;
    logic         cfg_wr;
    logic         ang_wr;
    logic         tr_start;
    logic         tr_bank;
    logic [47:0]  tr_angles;
    logic         tr_busy;
    sf4_coef_wr_t coef_wr;
    logic         adv;
    logic         take;
    logic [31:0]  abs_sc;

    logic [3:0][31:0]   fv0;
    logic [3:0][31:0]   fv1;
    logic [3:0][31:0]   fv2;
    logic signed [63:0] rnd;
    logic signed [63:0] rsh;
    logic [31:0]        lane_s;
    logic [47:0]        off_d;
    logic               off_hit;
    logic [64:0]        mag;
    logic [49:0]        mag_c;
    logic signed [50:0] fsum;

    function automatic logic [31:0] sat_lane(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -48'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    function automatic logic [31:0] neg_sat(input logic [31:0] a);
        if (a == 32'h8000_0000)
            return 32'h7FFF_FFFF;
        else
            return 32'(-a);
    endfunction

    // Conditional reflection of one lane pair; returns {new a, new b}.
    function automatic logic [63:0] fold2(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {a[31], a} + {b[31], b};
        if (sum[32])
            return {neg_sat(b), neg_sat(a)};
        else
            return {a, b};
    endfunction

    // ---------------- configuration ----------------
    assign cfg_idx  = sf4_reg_t'(paddr[5:3]);
    assign cfg_wr   = psel && penable && pwrite;
    assign ang_wr   = cfg_wr && (cfg_idx == REG_ANG_FIRST || cfg_idx == REG_ANG_SECOND);
    assign pready   = 1'b1;

    // Angle writes are queued per bank so that one arriving during a run is not lost.
    assign tr_start  = !tr_busy && (ang_pend_reg != 2'b00);
    assign tr_bank   = !ang_pend_reg[0];
    assign tr_angles = tr_bank ? ang_second_reg : ang_first_reg;

    always_comb
    begin
        ang_pend_next = ang_pend_reg;
        if (tr_start)
            ang_pend_next[tr_bank] = 1'b0;
        if (cfg_wr && cfg_idx == REG_ANG_FIRST)
            ang_pend_next[0] = 1'b1;
        if (cfg_wr && cfg_idx == REG_ANG_SECOND)
            ang_pend_next[1] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= 32'd33554432;
            offset_reg     <= 64'h1000_1000_1000_1000;
            off_win_reg    <= 16'hFF00;
            rot_ctrl_reg   <= 17'h0FF00;
            ang_first_reg  <= '0;
            ang_second_reg <= '0;
            gain_reg       <= 32'd16777216;
            de_off_reg     <= '0;
            ang_pend_reg   <= '0;
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                cos_reg[i] <= COEF_ONE;
                sin_reg[i] <= '0;
            end
        end
        else
        begin
            ang_pend_reg <= ang_pend_next;
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_SCALE:      scale_reg      <= pwdata[31:0];
                    REG_OFFSET:     offset_reg     <= pwdata;
                    REG_OFF_WIN:    off_win_reg    <= pwdata[15:0];
                    REG_ROT_CTRL:   rot_ctrl_reg   <= pwdata[16:0];
                    REG_ANG_FIRST:  ang_first_reg  <= pwdata[47:0];
                    REG_ANG_SECOND: ang_second_reg <= pwdata[47:0];
                    REG_DE_GAIN:    gain_reg       <= pwdata[31:0];
                    REG_DE_OFFSET:  de_off_reg     <= pwdata[47:0];
                    default:
                    begin
                    end
                endcase
            end
            if (coef_wr.we)
            begin
                for (int i = 0; i < NUM_PLANES; i++)
                begin
                    if (coef_wr.plane == 3'(i))
                    begin
                        cos_reg[i] <= coef_wr.cos_val;
                        sin_reg[i] <= coef_wr.sin_val;
                    end
                end
            end
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_SCALE:      prdata = {32'd0, scale_reg};
            REG_OFFSET:     prdata = offset_reg;
            REG_OFF_WIN:    prdata = {48'd0, off_win_reg};
            REG_ROT_CTRL:   prdata = {47'd0, rot_ctrl_reg};
            REG_ANG_FIRST:  prdata = {16'd0, ang_first_reg};
            REG_ANG_SECOND: prdata = {16'd0, ang_second_reg};
            REG_DE_GAIN:    prdata = {32'd0, gain_reg};
            REG_DE_OFFSET:  prdata = {16'd0, de_off_reg};
            default:        prdata = '0;
        endcase
    end

    sf4_trig u_trig (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (tr_start),
        .bank    (tr_bank),
        .angles  (tr_angles),
        .busy    (tr_busy),
        .coef_wr (coef_wr)
    );

    // ---------------- pipeline control ----------------
    assign adv          = !(vld_reg[LAST] && result_stall);
    assign point_stall  = !adv || tr_busy || ang_wr || (ang_pend_reg != 2'b00);
    assign take         = point_valid && !point_stall;
    assign result_valid = vld_reg[LAST];

    assign result.out_x      = st_reg[LAST].v[0];
    assign result.out_y      = st_reg[LAST].v[1];
    assign result.out_z      = st_reg[LAST].v[2];
    assign result.out_w      = st_reg[LAST].v[3];
    assign result.out_factor = st_reg[LAST].fac;

    assign abs_sc = scale_reg[31] ? 32'(-scale_reg) : scale_reg;

    // ---------------- folds, two per stage ----------------
    always_comb
    begin
        fv0 = {point.lane_w, point.lane_z, point.lane_y, point.lane_x};
        {fv0[0], fv0[1]} = fold2(fv0[0], fv0[1]);
        {fv0[0], fv0[2]} = fold2(fv0[0], fv0[2]);
        st_next[0].v   = fv0;
        st_next[0].p   = '0;
        st_next[0].it  = point.iteration;
        st_next[0].rot = 1'b0;
        st_next[0].fac = point.distance_factor;
    end

    always_comb
    begin
        fv1 = st_reg[0].v;
        {fv1[1], fv1[2]} = fold2(fv1[1], fv1[2]);
        {fv1[0], fv1[3]} = fold2(fv1[0], fv1[3]);
        st_next[1]   = st_reg[0];
        st_next[1].v = fv1;
    end

    always_comb
    begin
        fv2 = st_reg[1].v;
        {fv2[1], fv2[3]} = fold2(fv2[1], fv2[3]);
        {fv2[2], fv2[3]} = fold2(fv2[2], fv2[3]);
        st_next[2]   = st_reg[1];
        st_next[2].v = fv2;
    end

    // ---------------- scale products ----------------
    always_comb
    begin
        st_next[3] = st_reg[2];
        for (int i = 0; i < 4; i++)
        begin
            st_next[3].p[i] = 64'($signed(st_reg[2].v[i]) * $signed(scale_reg));
        end
    end

    // ---------------- rounding, offset, windows, factor result ----------------
    always_comb
    begin
        st_next[4] = st_reg[3];
        off_hit = (st_reg[3].it >= off_win_reg[7:0]) && (st_reg[3].it < off_win_reg[15:8]);
        rnd     = '0;
        rsh     = '0;
        lane_s  = '0;
        off_d   = '0;
        for (int i = 0; i < 4; i++)
        begin
            rnd    = $signed(st_reg[3].p[i]) + 64'sd8388608;
            rsh    = rnd >>> 24;
            lane_s = sat_lane(rsh[47:0]);
            off_d  = {{16{lane_s[31]}}, lane_s}
                   - {{20{offset_reg[16*i+15]}}, offset_reg[16*i +: 16], 12'd0};
            st_next[4].v[i] = off_hit ? sat_lane(off_d) : lane_s;
        end
        st_next[4].rot = rot_ctrl_reg[16] && (st_reg[3].it >= rot_ctrl_reg[7:0])
                         && (st_reg[3].it < rot_ctrl_reg[15:8]);

        mag   = full_reg[112:48];
        mag_c = (mag > 65'd562949953421312) ? 50'd562949953421312 : mag[49:0];
        fsum  = $signed({1'b0, mag_c}) + $signed({{3{de_off_reg[47]}}, de_off_reg});
        if (fsum < 0)
            st_next[4].fac = '0;
        else if (fsum > 51'sd281474976710655)
            st_next[4].fac = '1;
        else
            st_next[4].fac = fsum[47:0];
    end

    // ---------------- plane rotations, two stages each ----------------
    for (genvar g = 0; g < NUM_PLANES; g++)
    begin : g_rot
        localparam int SA = 5 + 2 * g;
        localparam int SB = 6 + 2 * g;
        localparam int LA = PLANE_A[g];
        localparam int LB = PLANE_B[g];

        logic signed [63:0] sum_a;
        logic signed [63:0] sum_b;
        logic signed [63:0] sh_a;
        logic signed [63:0] sh_b;

        always_comb
        begin
            st_next[SA]      = st_reg[SA-1];
            st_next[SA].p[0] = 64'($signed(st_reg[SA-1].v[LA]) * cos_reg[g]);
            st_next[SA].p[1] = 64'($signed(st_reg[SA-1].v[LB]) * sin_reg[g]);
            st_next[SA].p[2] = 64'($signed(st_reg[SA-1].v[LB]) * cos_reg[g]);
            st_next[SA].p[3] = 64'($signed(st_reg[SA-1].v[LA]) * sin_reg[g]);
        end

        always_comb
        begin
            st_next[SB] = st_reg[SB-1];
            sum_a = $signed(st_reg[SB-1].p[0]) + $signed(st_reg[SB-1].p[1]) + 64'sd32768;
            sum_b = $signed(st_reg[SB-1].p[2]) - $signed(st_reg[SB-1].p[3]) + 64'sd32768;
            sh_a  = sum_a >>> 16;
            sh_b  = sum_b >>> 16;
            if (st_reg[SB-1].rot)
            begin
                st_next[SB].v[LA] = sat_lane(sh_a[47:0]);
                st_next[SB].v[LB] = sat_lane(sh_b[47:0]);
            end
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        ag_reg <= 64'(abs_sc) * 64'(gain_reg);
        if (adv)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                st_reg[k] <= st_next[k];
            end
            // Factor product in 24 by 32 bit pieces, summed over two stages.
            fpp_reg[0] <= 56'(st_reg[0].fac[23:0])  * 56'(ag_reg[31:0]);
            fpp_reg[1] <= 56'(st_reg[0].fac[23:0])  * 56'(ag_reg[63:32]);
            fpp_reg[2] <= 56'(st_reg[0].fac[47:24]) * 56'(ag_reg[31:0]);
            fpp_reg[3] <= 56'(st_reg[0].fac[47:24]) * 56'(ag_reg[63:32]);
            fa_reg     <= 81'(fpp_reg[0]) + {1'b0, fpp_reg[2], 24'd0};
            fb_reg     <= 81'(fpp_reg[1]) + {1'b0, fpp_reg[3], 24'd0};
            full_reg   <= 113'(fa_reg) + {fb_reg, 32'd0} + (113'd1 << 47);
        end
    end

    // ---------------- assertions ----------------
    a_trig_starts: assert property (@(posedge clk) disable iff (!rst_n)
        tr_start |=> tr_busy)
        else $error("queued angle write did not start the trig sequencer");

    a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[LAST] == $past(vld_reg[LAST-1]))
        else $error("valid bit lost or invented between the last two stages");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while the result was stalled");

endmodule

### hdl/sf4_trig.sv
module sf4_trig (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  bank,
    input  logic [47:0]           angles,
    output logic                  busy,
    output sf4_pkg::sf4_coef_wr_t coef_wr
);
    import sf4_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE, T_MULR, T_TGET, T_SQ, T_T2GET, T_HMUL,
        T_DIVINIT, T_RLO, T_RHI, T_RSUM, T_HUPD, T_SMUL, T_OUT
    } tstate_t;

    tstate_t             state_reg;
    logic [47:0]         angles_reg;
    logic                bank_reg;
    logic [1:0]          plane_reg;
    logic [3:0]          step_reg;
    logic [30:0]         t_reg;
    logic [31:0]         t2_reg;
    logic signed [33:0]  h_reg;
    logic signed [33:0]  hs_reg;
    logic signed [67:0]  mul_reg;
    logic [32:0]         dq_reg;
    logic [52:0]         lo_reg;
    logic                neg_reg;
    sf4_coef_wr_t        coef_wr_reg;

    logic [15:0]         ang;
    logic signed [33:0]  mul_a;
    logic signed [33:0]  mul_b;
    logic [67:0]         mul_mag;
    logic [40:0]         recip;
    logic [73:0]         quot_full;
    logic signed [33:0]  quot_s;
    logic signed [33:0]  h_new;
    logic signed [17:0]  s_q16;
    logic signed [17:0]  c_q16;
    logic signed [17:0]  cos_o;
    logic signed [17:0]  sin_o;

    function automatic logic signed [17:0] q16_round(input logic signed [37:0] v);
        logic [37:0] r;
        if (v < 0) begin
            r = '0;
        end else begin
            r = (v + 38'd8192) >> 14;
        end
        if (r > 38'd65536) begin
            r = 38'd65536;
        end
        return r[17:0];
    endfunction

    always_comb
    begin
        ang   = angles_reg[{plane_reg, 4'b0000} +: 16];
        recip = RECIP_K[step_reg];
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            T_MULR:
            begin
                mul_a = {20'd0, ang[13:0]};
                mul_b = HALF_PI_Q30;
            end
            T_SQ:
            begin
                mul_a = {3'd0, t_reg};
                mul_b = {3'd0, t_reg};
            end
            T_HMUL:
            begin
                mul_a = {2'd0, t2_reg};
                mul_b = h_reg;
            end
            T_RLO:
            begin
                mul_a = {1'b0, dq_reg};
                mul_b = {14'd0, recip[19:0]};
            end
            T_RHI:
            begin
                mul_a = {1'b0, dq_reg};
                mul_b = {13'd0, recip[40:20]};
            end
            T_SMUL:
            begin
                mul_a = {3'd0, t_reg};
                mul_b = hs_reg;
            end
            default:
            begin
            end
        endcase

        mul_mag   = mul_reg[67] ? 68'(-mul_reg) : 68'(mul_reg);
        // The reciprocal is applied in two halves through the shared multiplier.
        quot_full = {mul_reg[53:0], 20'd0} + 74'(lo_reg);
        // The quotient of the truncated magnitude carries the product's sign.
        quot_s    = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
        h_new     = Q30_ONE - quot_s;

        s_q16 = q16_round(mul_reg[67:30]);
        c_q16 = q16_round({{4{h_reg[33]}}, h_reg});
        case (ang[15:14])
            2'd0:
            begin
                cos_o = c_q16;
                sin_o = s_q16;
            end
            2'd1:
            begin
                cos_o = -s_q16;
                sin_o = c_q16;
            end
            2'd2:
            begin
                cos_o = -c_q16;
                sin_o = -s_q16;
            end
            default:
            begin
                cos_o = s_q16;
                sin_o = -c_q16;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_IDLE;
            coef_wr_reg.we <= 1'b0;
        end
        else
        begin
            mul_reg        <= mul_a * mul_b;
            coef_wr_reg.we <= (state_reg == T_OUT);
            case (state_reg)
                T_IDLE:
                begin
                    if (start)
                    begin
                        angles_reg <= angles;
                        bank_reg   <= bank;
                        plane_reg  <= 2'd0;
                        state_reg  <= T_MULR;
                    end
                end
                T_MULR:
                begin
                    state_reg <= T_TGET;
                end
                T_TGET:
                begin
                    t_reg     <= mul_reg[44:14];
                    state_reg <= T_SQ;
                end
                T_SQ:
                begin
                    state_reg <= T_T2GET;
                end
                T_T2GET:
                begin
                    t2_reg    <= mul_reg[61:30];
                    h_reg     <= Q30_ONE;
                    step_reg  <= 4'd0;
                    state_reg <= T_HMUL;
                end
                T_HMUL:
                begin
                    state_reg <= T_DIVINIT;
                end
                T_DIVINIT:
                begin
                    dq_reg    <= mul_mag[62:30];
                    neg_reg   <= mul_reg[67];
                    state_reg <= T_RLO;
                end
                T_RLO:
                begin
                    state_reg <= T_RHI;
                end
                T_RHI:
                begin
                    lo_reg    <= mul_reg[52:0];
                    state_reg <= T_RSUM;
                end
                T_RSUM:
                begin
                    dq_reg    <= quot_full[73:41];
                    state_reg <= T_HUPD;
                end
                T_HUPD:
                begin
                    if (step_reg == 4'(SIN_STEPS - 1))
                    begin
                        hs_reg <= h_new;
                        h_reg  <= Q30_ONE;
                    end
                    else
                    begin
                        h_reg <= h_new;
                    end
                    if (step_reg == 4'(TRIG_STEPS - 1))
                    begin
                        state_reg <= T_SMUL;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= T_HMUL;
                    end
                end
                T_SMUL:
                begin
                    state_reg <= T_OUT;
                end
                T_OUT:
                begin
                    coef_wr_reg.plane   <= (bank_reg ? 3'd3 : 3'd0) + {1'b0, plane_reg};
                    coef_wr_reg.cos_val <= cos_o;
                    coef_wr_reg.sin_val <= sin_o;
                    if (plane_reg == 2'd2)
                    begin
                        state_reg <= T_IDLE;
                    end
                    else
                    begin
                        plane_reg <= plane_reg + 2'd1;
                        state_reg <= T_MULR;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != T_IDLE);
    assign coef_wr = coef_wr_reg;

endmodule

### bench/sierpinski_4d_fold_rotate_step_test.sv
module sierpinski_4d_fold_rotate_step_test;
    import sf4_pkg::*;

    localparam int LATENCY     = 40;
    localparam int CYCLE_LIMIT = 600000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        point_valid = 1'b0;
    logic        point_stall;
    sf4_point_t  point = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    sf4_result_t result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    sierpinski_4d_fold_rotate_step uut (
        .clk(clk), .rst_n(rst_n),
        .point_valid(point_valid), .point_stall(point_stall), .point(point),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Shadow copy of the register file and the rotation coefficients.
    bit [31:0] scale_reg;
    bit [63:0] offset_reg;
    bit [15:0] off_win_reg;
    bit [16:0] rot_ctrl_reg;
    bit [47:0] ang_first_reg;
    bit [47:0] ang_second_reg;
    bit [31:0] gain_reg;
    bit [47:0] de_off_reg;
    longint    coef [12];

    sf4_point_t  pending_points [$];
    sf4_result_t expected_results [$];
    int          idle_pct = 8;
    int          errors = 0;
    int          points_sent = 0;
    int          results_seen = 0;
    int          cycles = 0;

    function automatic longint sat_lane(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint q30_to_coef(longint v);
        longint r;
        if (v < 0)
            v = 0;
        r = (v + 8192) >>> 14;
        return (r > 65536) ? 65536 : r;
    endfunction

    task automatic angle_to_coef(input bit [15:0] ang, output longint co, output longint si);
        longint    sk [5];
        longint    ck [6];
        longint    t, t2, hs, hc, s, c;
        bit [63:0] u;
        sk = '{110, 72, 42, 20, 6};
        ck = '{132, 90, 56, 30, 12, 2};
        t = (longint'(ang[13:0]) * 64'sd1686629713) >>> 14;
        u = t * t;
        t2 = longint'(u >> 30);
        hs = 64'sd1 << 30;
        hc = 64'sd1 << 30;
        for (int i = 0; i < 5; i++)
            hs = (64'sd1 << 30) - (t2 * hs) / (sk[i] << 30);
        for (int i = 0; i < 6; i++)
            hc = (64'sd1 << 30) - (t2 * hc) / (ck[i] << 30);
        u = t * hs;
        s = q30_to_coef(longint'(u >> 30));
        c = q30_to_coef(hc);
        case (ang[15:14])
            2'd0: begin co = c;  si = s;  end
            2'd1: begin co = -s; si = c;  end
            2'd2: begin co = -c; si = -s; end
            default: begin co = s; si = -c; end
        endcase
    endtask

    function automatic bit in_window(bit [15:0] win, bit [7:0] it);
        return it >= win[7:0] && it < win[15:8];
    endfunction

    function automatic sf4_result_t fold_step(sf4_point_t p);
        longint      v [4];
        longint      sc, na, nb, sum, off, c, s;
        int          pa [6];
        int          pb [6];
        int          fa [6];
        int          fb [6];
        bit [15:0]   ang;
        bit [127:0]  prod;
        bit [63:0]   mag;
        sf4_result_t r;
        pa = '{0, 1, 0, 0, 1, 2};
        pb = '{1, 2, 2, 3, 3, 3};
        fa = '{0, 0, 1, 0, 1, 2};
        fb = '{1, 2, 2, 3, 3, 3};
        v[0] = p.lane_x;
        v[1] = p.lane_y;
        v[2] = p.lane_z;
        v[3] = p.lane_w;
        sc = longint'(signed'(scale_reg));
        // Reflections run over xy, xz, yz, xw, yw, zw in that order.
        for (int i = 0; i < 6; i++) begin
            if (v[fa[i]] + v[fb[i]] < 0) begin
                na = sat_lane(-v[fb[i]]);
                nb = sat_lane(-v[fa[i]]);
                v[fa[i]] = na;
                v[fb[i]] = nb;
            end
        end
        for (int i = 0; i < 4; i++)
            v[i] = sat_lane((v[i] * sc + (64'sd1 <<< 23)) >>> 24);
        if (in_window(off_win_reg, p.iteration)) begin
            for (int i = 0; i < 4; i++) begin
                off = longint'(signed'(offset_reg[16*i +: 16]));
                v[i] = sat_lane(v[i] - off * 4096);
            end
        end
        if (rot_ctrl_reg[16] && in_window(rot_ctrl_reg[15:0], p.iteration)) begin
            for (int i = 0; i < 6; i++) begin
                ang = (i < 3) ? ang_first_reg[16*i +: 16] : ang_second_reg[16*(i-3) +: 16];
                if (ang != 0) begin
                    c = coef[2*i];
                    s = coef[2*i+1];
                    na = sat_lane((v[pa[i]] * c + v[pb[i]] * s + 32768) >>> 16);
                    nb = sat_lane((v[pb[i]] * c - v[pa[i]] * s + 32768) >>> 16);
                    v[pa[i]] = na;
                    v[pb[i]] = nb;
                end
            end
        end
        prod = 128'(p.distance_factor) * 128'(sc < 0 ? -sc : sc) * 128'(gain_reg);
        prod = prod + (128'd1 << 47);
        mag = prod[111:48];
        if (mag > (64'd1 << 49))
            mag = 64'd1 << 49;
        sum = longint'(mag) + longint'(signed'(de_off_reg));
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd281474976710655)
            sum = 64'sd281474976710655;
        r.out_x = v[0][31:0];
        r.out_y = v[1][31:0];
        r.out_z = v[2][31:0];
        r.out_w = v[3][31:0];
        r.out_factor = sum[47:0];
        return r;
    endfunction

    task automatic write_reg(sf4_reg_t idx, bit [63:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 6'(idx) << 3;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SCALE:      scale_reg = val[31:0];
            REG_OFFSET:     offset_reg = val;
            REG_OFF_WIN:    off_win_reg = val[15:0];
            REG_ROT_CTRL:   rot_ctrl_reg = val[16:0];
            REG_ANG_FIRST:
            begin
                ang_first_reg = val[47:0];
                for (int p = 0; p < 3; p++)
                    angle_to_coef(val[16*p +: 16], coef[2*p], coef[2*p+1]);
            end
            REG_ANG_SECOND:
            begin
                ang_second_reg = val[47:0];
                for (int p = 0; p < 3; p++)
                    angle_to_coef(val[16*p +: 16], coef[2*p+6], coef[2*p+7]);
            end
            REG_DE_GAIN:    gain_reg = val[31:0];
            REG_DE_OFFSET:  de_off_reg = val[47:0];
            default:        ;
        endcase
    endtask

    function automatic bit [31:0] pick_lane();
        case ($urandom_range(5))
            0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            1: return 32'($signed($urandom_range(67108864)) - 33554432);
            default: return $urandom;
        endcase
    endfunction

    function automatic sf4_point_t random_point();
        sf4_point_t p;
        p.lane_x = pick_lane();
        p.lane_y = pick_lane();
        p.lane_z = pick_lane();
        p.lane_w = pick_lane();
        p.iteration = $urandom_range(3) == 0 ? 8'($urandom_range(12)) : 8'($urandom);
        case ($urandom_range(3))
            0: p.distance_factor = 48'({$urandom, $urandom});
            1: p.distance_factor = 48'hFFFF_FFFF_FFFF;
            default: p.distance_factor = 48'($urandom_range(1 << 28));
        endcase
        return p;
    endfunction

    task automatic drain();
        while (pending_points.size() != 0 || expected_results.size() != 0 || point_valid)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic random_config(int mode);
        bit [63:0] r64;
        r64 = {$urandom, $urandom};
        case (mode)
            0: write_reg(REG_SCALE, $urandom_range(1) ? 64'h8000_0000 : 64'h7FFF_FFFF);
            1: write_reg(REG_SCALE, 64'hFE00_0000);
            default: write_reg(REG_SCALE, 64'($urandom_range(100663296)) - 64'd50331648);
        endcase
        write_reg(REG_OFFSET, mode == 0 ? 64'h8000_7FFF_FFFF_0000 : r64);
        write_reg(REG_OFF_WIN, mode == 1 ? 64'h0000_05_09 : 64'($urandom_range(16'hFFFF)));
        write_reg(REG_ROT_CTRL, mode == 0 ? 64'h1_FF_00 :
                  {47'd0, 1'($urandom_range(3) != 0), 8'($urandom_range(255)),
                   8'($urandom_range(6))});
        write_reg(REG_ANG_FIRST, mode == 0 ? 64'hC000_8000_4000 : 64'($urandom) << 16 | $urandom_range(65535));
        write_reg(REG_ANG_SECOND, mode == 0 ? 64'hFFFF_0001_0000 : {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
        write_reg(REG_DE_GAIN, mode == 0 ? 64'hFFFF_FFFF : 64'($urandom));
        case (mode)
            0: write_reg(REG_DE_OFFSET, 64'h8000_0000_0000);
            1: write_reg(REG_DE_OFFSET, 64'h7FFF_FFFF_FFFF);
            default: write_reg(REG_DE_OFFSET, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF);
        endcase
    endtask

    // Driver: a request stays on the port until it is taken.
    always @(posedge clk) begin
        if (rst_n) begin
            if (point_valid && !point_stall) begin
                expected_results.push_back(fold_step(point));
                points_sent++;
            end
            if (!point_valid || !point_stall) begin
                if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    point <= pending_points.pop_front();
                    point_valid <= 1'b1;
                end
                else
                    point_valid <= 1'b0;
            end
        end
    end

    // Monitor
    always @(posedge clk) begin
        if (rst_n) begin
            if (result_valid && !result_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, result);
                end
                else begin
                    sf4_result_t e;
                    e = expected_results.pop_front();
                    if (e.out_x !== result.out_x)
                        $display("%0t: out_x expected %h actual %h", $time, e.out_x, result.out_x);
                    if (e.out_y !== result.out_y)
                        $display("%0t: out_y expected %h actual %h", $time, e.out_y, result.out_y);
                    if (e.out_z !== result.out_z)
                        $display("%0t: out_z expected %h actual %h", $time, e.out_z, result.out_z);
                    if (e.out_w !== result.out_w)
                        $display("%0t: out_w expected %h actual %h", $time, e.out_w, result.out_w);
                    if (e.out_factor !== result.out_factor)
                        $display("%0t: out_factor expected %h actual %h", $time,
                                 e.out_factor, result.out_factor);
                    if (e !== result)
                        errors++;
                end
            end
            result_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        sf4_point_t p;
        scale_reg = 32'h0200_0000;
        offset_reg = 64'h1000_1000_1000_1000;
        off_win_reg = 16'hFF00;
        rot_ctrl_reg = 17'h0FF00;
        ang_first_reg = '0;
        ang_second_reg = '0;
        gain_reg = 32'h0100_0000;
        de_off_reg = '0;
        for (int i = 0; i < 12; i++)
            coef[i] = (i % 2 == 0) ? 65536 : 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at reset settings: lane extremes, folds, window edges.
        for (int i = 0; i < 20; i++) begin
            p.lane_x = (i % 4 == 0) ? 32'h8000_0000 : (i % 4 == 1) ? 32'h7FFF_FFFF : -(i << 20);
            p.lane_y = (i % 3 == 0) ? 32'h8000_0000 : (i << 22);
            p.lane_z = (i % 5 == 0) ? 32'h7FFF_FFFF : -(i << 21);
            p.lane_w = (i % 2 == 0) ? 32'h8000_0000 : 32'h0;
            p.iteration = (i < 10) ? 8'(i) : 8'(250 + i % 6);
            p.distance_factor = (i % 2) ? 48'hFFFF_FFFF_FFFF : 48'(i);
            pending_points.push_back(p);
        end
        drain();

        for (int phase = 0; phase < 7; phase++) begin
            random_config(phase);
            idle_pct = (phase == 3) ? 0 : 8;
            for (int i = 0; i < 240; i++) begin
                pending_points.push_back(random_point());
                // The sender holds off once until the block has emptied.
                if (phase == 2 && i == 120)
                    while (pending_points.size() != 0 || expected_results.size() != 0
                           || point_valid)
                        @(posedge clk);
            end
            drain();
        end

        $display("%0d points sent, %0d results checked over 8 register settings,", points_sent,
                 results_seen);
        $display("with extreme scale, offsets, windows and all angle quadrants.");
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
hdl/sf4_pkg.sv
hdl/sf4_trig.sv
hdl/sierpinski_4d_fold_rotate_step.sv
bench/sierpinski_4d_fold_rotate_step_test.sv
